// ===== src/tgi_pkg.sv =====
// tgi_pkg: shared types and constants of the trilinear grid interpolator.
// Item and lane structs, item kind and status codes, sequencer state and corner phase types.
// No dependencies.
package tgi_pkg;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    KIND_LOAD_X = 3'd0,
    KIND_LOAD_Y = 3'd1,
    KIND_LOAD_Z = 3'd2,
    KIND_LOAD_S = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_OUT_OF_BOX    = 2'd1,
    STATUS_NOT_ASCENDING = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [11:0]        slot;
    logic signed [31:0] load_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interpolated;
    status_e            status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_CORNER,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_READ,
    PH_MUL2,
    PH_ROUND,
    PH_PROD,
    PH_ACC,
    PH_FIN
  } phase_e;

  typedef struct packed {
    logic scan_rd;
    logic div_start;
    logic div_step;
  } lane_ctrl_t;

  typedef struct packed {
    logic in_box;
    logic ascending;
  } lane_stat_t;

endpackage

// ===== src/trilinear_grid_interpolator_unit.sv =====
// Trilinear grid interpolator, top level: item handshake, query sequencer, three axis
// lanes and the corner merge. Depends on tgi_pkg, tgi_lane and tgi_merge.
//
// Load items (x, y, z axis or sample) are taken while the sequencer is idle and give no result.
// A query is a scan, a divide and a merge: the three lanes scan their axis tables side
// by side, the bit-serial fraction dividers form the fractions, and the merge reads the
// eight corners from the sample memory one at a time and weights them. The block takes
// one query at a time; a finished result sits in an output register, so the next item
// is accepted while it waits.
// Points outside the axis box return status 1; a table that is not strictly ascending
// returns status 2; in both cases the value is 0.
module trilinear_grid_interpolator_unit #(
  parameter int GRID_N = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tgi_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tgi_pkg::out_item_t out_item_o
);

  localparam int IW  = $clog2(GRID_N);
  localparam int SAW = $clog2(GRID_N**3);
  localparam int CW  = $clog2(GRID_N + 18);
  localparam logic [CW-1:0] DIV_LAST = CW'(17);

  tgi_pkg::state_e    state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  tgi_pkg::in_item_t  req_q;
  tgi_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] res_q, res_d;
  tgi_pkg::status_e   st_q, st_d;

  logic               accept, slot_axis, slot_sample;
  tgi_pkg::lane_ctrl_t ctrl;
  tgi_pkg::lane_stat_t stat_x, stat_y, stat_z;
  logic [IW-1:0]      cell_x, cell_y, cell_z;
  logic [16:0]        frac_x, frac_y, frac_z;
  logic               merge_start, merge_done;
  logic signed [31:0] merge_res;
  tgi_pkg::status_e   status;

  assign accept      = in_valid_i && in_ready_o;
  assign slot_axis   = in_item_i.slot < 12'(GRID_N);
  assign slot_sample = {20'b0, in_item_i.slot} < 32'(GRID_N**3);

  tgi_lane #(.GRID_N(GRID_N)) u_lane_x (
    .clk_i, .rst_ni,
    .wr_en_i   (accept && slot_axis && in_item_i.kind == tgi_pkg::KIND_LOAD_X),
    .wr_addr_i (IW'(in_item_i.slot)),
    .wr_data_i (in_item_i.load_value),
    .rd_addr_i (cnt_q[IW-1:0]),
    .ctrl_i    (ctrl),
    .coord_i   (req_q.query_x),
    .stat_o    (stat_x),
    .cell_o    (cell_x),
    .frac_o    (frac_x)
  );

  tgi_lane #(.GRID_N(GRID_N)) u_lane_y (
    .clk_i, .rst_ni,
    .wr_en_i   (accept && slot_axis && in_item_i.kind == tgi_pkg::KIND_LOAD_Y),
    .wr_addr_i (IW'(in_item_i.slot)),
    .wr_data_i (in_item_i.load_value),
    .rd_addr_i (cnt_q[IW-1:0]),
    .ctrl_i    (ctrl),
    .coord_i   (req_q.query_y),
    .stat_o    (stat_y),
    .cell_o    (cell_y),
    .frac_o    (frac_y)
  );

  tgi_lane #(.GRID_N(GRID_N)) u_lane_z (
    .clk_i, .rst_ni,
    .wr_en_i   (accept && slot_axis && in_item_i.kind == tgi_pkg::KIND_LOAD_Z),
    .wr_addr_i (IW'(in_item_i.slot)),
    .wr_data_i (in_item_i.load_value),
    .rd_addr_i (cnt_q[IW-1:0]),
    .ctrl_i    (ctrl),
    .coord_i   (req_q.query_z),
    .stat_o    (stat_z),
    .cell_o    (cell_z),
    .frac_o    (frac_z)
  );

  tgi_merge #(.GRID_N(GRID_N)) u_merge (
    .clk_i, .rst_ni,
    .wr_en_i   (accept && slot_sample && in_item_i.kind == tgi_pkg::KIND_LOAD_S),
    .wr_addr_i (SAW'(in_item_i.slot)),
    .wr_data_i (in_item_i.load_value),
    .start_i   (merge_start),
    .cell_x_i  (cell_x),
    .cell_y_i  (cell_y),
    .cell_z_i  (cell_z),
    .frac_x_i  (frac_x),
    .frac_y_i  (frac_y),
    .frac_z_i  (frac_z),
    .done_o    (merge_done),
    .result_o  (merge_res)
  );

  // Box test takes priority over the order test.
  always_comb begin
    if (!(stat_x.in_box && stat_y.in_box && stat_z.in_box)) begin
      status = tgi_pkg::STATUS_OUT_OF_BOX;
    end else if (!(stat_x.ascending && stat_y.ascending && stat_z.ascending)) begin
      status = tgi_pkg::STATUS_NOT_ASCENDING;
    end else begin
      status = tgi_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgi_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_item_i;
    out_q <= out_d;
    res_q <= res_d;
    st_q  <= st_d;
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    res_d          = res_q;
    st_d           = st_q;
    ctrl.scan_rd   = 1'b0;
    ctrl.div_start = 1'b0;
    ctrl.div_step  = 1'b0;
    merge_start    = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      tgi_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_item_i.kind == tgi_pkg::KIND_QUERY) begin
          state_d = tgi_pkg::S_SCAN;
          cnt_d   = '0;
        end
      end
      tgi_pkg::S_SCAN: begin
        ctrl.scan_rd = cnt_q < CW'(GRID_N);
        cnt_d        = cnt_q + CW'(1);
        if (cnt_q == CW'(GRID_N)) begin
          state_d = tgi_pkg::S_DIV;
          cnt_d   = '0;
        end
      end
      tgi_pkg::S_DIV: begin
        ctrl.div_start = cnt_q == '0;
        ctrl.div_step  = cnt_q != '0;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = tgi_pkg::S_CORNER;
          cnt_d   = '0;
        end
      end
      tgi_pkg::S_CORNER: begin
        if (cnt_q == '0) begin
          cnt_d = CW'(1);
          if (status != tgi_pkg::STATUS_OK) begin
            res_d   = '0;
            st_d    = status;
            state_d = tgi_pkg::S_DONE;
          end else begin
            merge_start = 1'b1;
          end
        end else if (merge_done) begin
          res_d   = merge_res;
          st_d    = tgi_pkg::STATUS_OK;
          state_d = tgi_pkg::S_DONE;
        end
      end
      tgi_pkg::S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.interpolated = res_q;
          out_d.status       = st_q;
          out_valid_d        = 1'b1;
          state_d            = tgi_pkg::S_IDLE;
        end
      end
      default: state_d = tgi_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/tgi_ram.sv =====
// tgi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tgi_lane.sv =====
// tgi_lane: one axis lane. Holds the axis table, scans it for min, max, order and cell,
// then forms the Q1.16 fraction with a restoring divider, one quotient bit a cycle.
// Depends on tgi_pkg and tgi_ram.
module tgi_lane #(
  parameter int GRID_N = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [$clog2(GRID_N)-1:0]     wr_addr_i,
  input  logic signed [31:0]            wr_data_i,
  input  logic [$clog2(GRID_N)-1:0]     rd_addr_i,
  input  tgi_pkg::lane_ctrl_t           ctrl_i,
  input  logic signed [31:0]            coord_i,
  output tgi_pkg::lane_stat_t           stat_o,
  output logic [$clog2(GRID_N)-1:0]     cell_o,
  output logic [16:0]                   frac_o
);

  localparam int IW = $clog2(GRID_N);

  logic [31:0]        rdata;
  logic signed [31:0] d;
  logic               rd_vld_q;
  logic [IW-1:0]      rd_idx_q;
  logic signed [31:0] min_q, max_q, prev_q, lo_q, hi_q;
  logic signed [31:0] min_d, max_d, prev_d, lo_d, hi_d;
  logic               asc_q, asc_d;
  logic [IW-1:0]      cell_q, cell_d;
  logic signed [32:0] num;
  logic [32:0]        den;
  logic [33:0]        rem_q, rem_d, shifted;
  logic [16:0]        quo_q, quo_d;
  logic               first_q, first_d;

  tgi_ram #(.WIDTH(32), .DEPTH(GRID_N)) u_axis (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign d = signed'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      first_q  <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.scan_rd;
      rd_idx_q <= rd_addr_i;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    max_q  <= max_d;
    prev_q <= prev_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    asc_q  <= asc_d;
    cell_q <= cell_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  // Scan: (prev, d) is cell idx-1; take cell 0, then any later one whose lower end is <= coord.
  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    prev_d = prev_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    asc_d  = asc_q;
    cell_d = cell_q;
    if (rd_vld_q) begin
      prev_d = d;
      if (rd_idx_q == '0) begin
        min_d = d;
        max_d = d;
        asc_d = 1'b1;
      end else begin
        if (d < min_q) min_d = d;
        if (d > max_q) max_d = d;
        if (d <= prev_q) asc_d = 1'b0;
        if ((rd_idx_q == IW'(1)) || (prev_q <= coord_i)) begin
          lo_d   = prev_q;
          hi_d   = d;
          cell_d = rd_idx_q - IW'(1);
        end
      end
    end
  end

  assign num = {coord_i[31], coord_i} - {lo_q[31], lo_q};
  assign den = 33'({hi_q[31], hi_q} - {lo_q[31], lo_q});
  assign shifted = first_q ? rem_q : {rem_q[32:0], 1'b0};

  // Divide: in a valid query num never exceeds the cell width, so the quotient has 17 bits.
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    first_d = first_q;
    if (ctrl_i.div_start) begin
      rem_d   = num[32] ? '0 : {1'b0, num};
      quo_d   = '0;
      first_d = 1'b1;
    end else if (ctrl_i.div_step) begin
      first_d = 1'b0;
      if (shifted >= {1'b0, den}) begin
        rem_d = shifted - {1'b0, den};
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[15:0], 1'b0};
      end
    end
  end

  assign stat_o.in_box    = (coord_i >= min_q) && (coord_i <= max_q);
  assign stat_o.ascending = asc_q;
  assign cell_o = cell_q;
  assign frac_o = (quo_q > tgi_pkg::ONE_Q16) ? tgi_pkg::ONE_Q16 : quo_q;

endmodule

// ===== src/tgi_merge.sv =====
// tgi_merge: corner merge. Holds the sample store, reads the eight corners one at a time,
// weights each by the product of the lane weights and sums into a Q32.32 accumulator.
// Depends on tgi_pkg and tgi_ram.
module tgi_merge #(
  parameter int GRID_N = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [$clog2(GRID_N**3)-1:0]         wr_addr_i,
  input  logic signed [31:0]                   wr_data_i,
  input  logic                                 start_i,
  input  logic [$clog2(GRID_N)-1:0]            cell_x_i,
  input  logic [$clog2(GRID_N)-1:0]            cell_y_i,
  input  logic [$clog2(GRID_N)-1:0]            cell_z_i,
  input  logic [16:0]                          frac_x_i,
  input  logic [16:0]                          frac_y_i,
  input  logic [16:0]                          frac_z_i,
  output logic                                 done_o,
  output logic signed [31:0]                   result_o
);

  localparam int IW  = $clog2(GRID_N);
  localparam int SAW = $clog2(GRID_N**3);

  logic                busy_q;
  tgi_pkg::phase_e     phase_q;
  logic [2:0]          corner_q;
  logic [16:0]         wx, wy, wz;
  logic [IW:0]         ix, jx, kx;
  logic [SAW-1:0]      raddr;
  logic [31:0]         rdata;
  logic [33:0]         p1_q;
  logic [50:0]         p2_q;
  logic [16:0]         w_q;
  logic signed [31:0]  sample_q;
  logic signed [49:0]  prod_q;
  logic signed [63:0]  acc_q;
  logic signed [63:0]  rnd;
  logic [50:0]         p2_rnd;

  assign wx = corner_q[2] ? frac_x_i : tgi_pkg::ONE_Q16 - frac_x_i;
  assign wy = corner_q[1] ? frac_y_i : tgi_pkg::ONE_Q16 - frac_y_i;
  assign wz = corner_q[0] ? frac_z_i : tgi_pkg::ONE_Q16 - frac_z_i;
  assign ix = {1'b0, cell_x_i} + (IW+1)'(corner_q[2]);
  assign jx = {1'b0, cell_y_i} + (IW+1)'(corner_q[1]);
  assign kx = {1'b0, cell_z_i} + (IW+1)'(corner_q[0]);
  assign raddr = SAW'(ix) * SAW'(GRID_N * GRID_N) + SAW'(jx) * SAW'(GRID_N) + SAW'(kx);
  assign p2_rnd = p2_q + 51'h0_8000_0000;

  tgi_ram #(.WIDTH(32), .DEPTH(GRID_N**3)) u_samples (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      phase_q  <= tgi_pkg::PH_READ;
      corner_q <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      phase_q  <= tgi_pkg::PH_READ;
      corner_q <= '0;
    end else if (busy_q) begin
      unique case (phase_q)
        tgi_pkg::PH_READ:  phase_q <= tgi_pkg::PH_MUL2;
        tgi_pkg::PH_MUL2:  phase_q <= tgi_pkg::PH_ROUND;
        tgi_pkg::PH_ROUND: phase_q <= tgi_pkg::PH_PROD;
        tgi_pkg::PH_PROD:  phase_q <= tgi_pkg::PH_ACC;
        tgi_pkg::PH_ACC: begin
          corner_q <= corner_q + 3'd1;
          phase_q  <= (corner_q == 3'd7) ? tgi_pkg::PH_FIN : tgi_pkg::PH_READ;
        end
        tgi_pkg::PH_FIN: begin
          busy_q  <= 1'b0;
          phase_q <= tgi_pkg::PH_READ;
        end
        default: phase_q <= tgi_pkg::PH_READ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (busy_q && (phase_q == tgi_pkg::PH_ACC)) begin
      acc_q <= acc_q + 64'(prod_q);
    end
    if (phase_q == tgi_pkg::PH_READ)  p1_q     <= wx * wy;
    if (phase_q == tgi_pkg::PH_MUL2)  begin
      p2_q     <= p1_q * wz;
      sample_q <= signed'(rdata);
    end
    if (phase_q == tgi_pkg::PH_ROUND) w_q      <= p2_rnd[48:32];
    if (phase_q == tgi_pkg::PH_PROD)  prod_q   <= sample_q * signed'({1'b0, w_q});
  end

  // Round half up to Q16.16, then saturate.
  assign rnd = (acc_q + 64'sd32768) >>> 16;

  always_comb begin
    if (rnd > 64'sd2147483647) begin
      result_o = 32'sh7FFF_FFFF;
    end else if (rnd < -64'sd2147483648) begin
      result_o = 32'sh8000_0000;
    end else begin
      result_o = rnd[31:0];
    end
  end

  assign done_o = busy_q && (phase_q == tgi_pkg::PH_FIN);

endmodule

// ===== src/tgi_checker.sv =====
// tgi_checker: port-level assertions for the trilinear grid interpolator, and the bind
// that attaches them to the top level. Depends on tgi_pkg.
module tgi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input tgi_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tgi_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != tgi_pkg::STATUS_OK |-> out_item_o.interpolated == 0)
    else $error("nonzero value with error status");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.kind == tgi_pkg::KIND_QUERY |=> !in_ready_o)
    else $error("input taken while a query is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.kind == tgi_pkg::KIND_QUERY |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a query");

endmodule

bind trilinear_grid_interpolator_unit tgi_checker u_tgi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/trilinear_grid_interpolator_unit_tb.sv =====
// Testbench for trilinear_grid_interpolator_unit: loads grids, runs queries and checks
// each result against an in-bench fixed-point predictor. Depends on tgi_pkg and the RTL.
module trilinear_grid_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 16;
  localparam int DEPTH = N * N * N;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  tgi_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  tgi_pkg::out_item_t out_item_o;

  trilinear_grid_interpolator_unit #(.GRID_N(N)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // predictor state
  logic signed [31:0] ax_tab [3][N];
  logic signed [31:0] field_mem [DEPTH];
  tgi_pkg::out_item_t pending_q [$];
  int                 err_cnt = 0;
  bit                 quiet_rx = 0;
  int                 hold_cycles = 0;
  int                 idle_pct = 6;

  function automatic bit axis_sorted(int a);
    for (int n = 1; n < N; n++) if (ax_tab[a][n] <= ax_tab[a][n-1]) return 0;
    return 1;
  endfunction

  function automatic bit axis_holds(int a, logic signed [31:0] v);
    logic signed [31:0] lo, hi;
    lo = ax_tab[a][0];
    hi = ax_tab[a][0];
    for (int n = 1; n < N; n++) begin
      if (ax_tab[a][n] < lo) lo = ax_tab[a][n];
      if (ax_tab[a][n] > hi) hi = ax_tab[a][n];
    end
    return v >= lo && v <= hi;
  endfunction

  function automatic int find_cell(int a, logic signed [31:0] v, output longint frac);
    int cnt, c;
    longint num, den;
    cnt = 0;
    for (int n = 0; n < N; n++) if (ax_tab[a][n] <= v) cnt++;
    c = cnt - 1;
    if (c > N - 2) c = N - 2;
    if (c < 0) c = 0;
    num = longint'(v) - longint'(ax_tab[a][c]);
    den = longint'(ax_tab[a][c+1]) - longint'(ax_tab[a][c]);
    if (num < 0) num = 0;
    frac = (num * 65536) / den;
    if (frac > 65536) frac = 65536;
    return c;
  endfunction

  function automatic tgi_pkg::out_item_t interpolate(tgi_pkg::in_item_t it);
    tgi_pkg::out_item_t r;
    int cidx [3];
    longint fr [3];
    logic signed [31:0] q [3];
    logic [127:0] sum, w, wx, wy, wz, rnd;
    r = '0;
    q[0] = it.query_x;
    q[1] = it.query_y;
    q[2] = it.query_z;
    if (!axis_holds(0, q[0]) || !axis_holds(1, q[1]) || !axis_holds(2, q[2])) begin
      r.status = tgi_pkg::STATUS_OUT_OF_BOX;
      return r;
    end
    if (!axis_sorted(0) || !axis_sorted(1) || !axis_sorted(2)) begin
      r.status = tgi_pkg::STATUS_NOT_ASCENDING;
      return r;
    end
    for (int a = 0; a < 3; a++) cidx[a] = find_cell(a, q[a], fr[a]);
    sum = '0;
    for (int c = 0; c < 8; c++) begin
      wx = c[2] ? fr[0] : 65536 - fr[0];
      wy = c[1] ? fr[1] : 65536 - fr[1];
      wz = c[0] ? fr[2] : 65536 - fr[2];
      w = (wx * wy * wz + 128'h8000_0000) >> 32;
      sum = sum + 128'($signed(field_mem[((cidx[0] + c[2]) * N + cidx[1] + c[1]) * N
                                           + cidx[2] + c[0]])) * w;
    end
    rnd = $signed(sum + 128'd32768) >>> 16;
    if ($signed(rnd) > $signed(128'sd2147483647)) r.interpolated = 32'h7fff_ffff;
    else if ($signed(rnd) < -$signed(128'sd2147483648)) r.interpolated = 32'h8000_0000;
    else r.interpolated = rnd[31:0];
    r.status = tgi_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic void track_item(tgi_pkg::in_item_t it);
    case (it.kind)
      tgi_pkg::KIND_LOAD_X, tgi_pkg::KIND_LOAD_Y, tgi_pkg::KIND_LOAD_Z:
        if (it.slot < N) ax_tab[it.kind][it.slot] = it.load_value;
      tgi_pkg::KIND_LOAD_S: field_mem[it.slot] = it.load_value;
      tgi_pkg::KIND_QUERY: pending_q.push_back(interpolate(it));
      default: ;
    endcase
  endfunction

  // result side: sample at rising edge, change ready at falling edge
  always @(posedge clk_i) begin
    tgi_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending");
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_item_o.interpolated !== exp_r.interpolated) begin
          $error("interpolated exp %0d got %0d", exp_r.interpolated, out_item_o.interpolated);
          err_cnt++;
        end
        if (out_item_o.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_item_o.status);
          err_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_rx || ($urandom_range(99) >= idle_pct);
    end
  end

  // Valid stays high after an item goes in; drop it only to idle or to drain.
  task automatic send(tgi_pkg::in_item_t it);
    while (!quiet_rx && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    track_item(it);
    @(negedge clk_i);
  endtask

  function automatic tgi_pkg::in_item_t mk(tgi_pkg::kind_e k, int s, logic [31:0] v);
    tgi_pkg::in_item_t it;
    it = '0;
    it.kind = k;
    it.slot = 12'(s);
    it.load_value = v;
    return it;
  endfunction

  function automatic tgi_pkg::in_item_t mk_q(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
    tgi_pkg::in_item_t it;
    it.kind = tgi_pkg::KIND_QUERY;
    it.slot = 12'($urandom);
    it.load_value = $urandom;
    it.query_x = x;
    it.query_y = y;
    it.query_z = z;
    return it;
  endfunction

  // ascending axis of random spacing starting at base
  task automatic load_axis(int a, logic signed [31:0] base, int max_step);
    logic signed [31:0] v;
    v = base;
    for (int n = 0; n < N; n++) begin
      send(mk(tgi_pkg::kind_e'(a), n, v));
      v = v + 1 + $urandom_range(max_step);
    end
  endtask

  // Load the corners of the first and last cell on every axis; queries stay there.
  task automatic load_field(bit full, int bound);
    int e [4] = '{0, 1, N - 2, N - 1};
    int s;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          s = (e[i] * N + e[j]) * N + e[k];
          if (full) send(mk(tgi_pkg::KIND_LOAD_S, s, $urandom));
          else send(mk(tgi_pkg::KIND_LOAD_S, s, $urandom_range(2 * bound) - bound));
        end
      end
    end
  endtask

  function automatic logic [31:0] pick_in(int a);
    int c;
    c = $urandom_range(1) ? N - 2 : 0;
    case ($urandom_range(5))
      0: return ax_tab[a][0];
      1: return ax_tab[a][N-1];
      2: return ax_tab[a][c];
      default: return ax_tab[a][c] + $urandom_range(ax_tab[a][c+1] - ax_tab[a][c] - 1);
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  typedef struct {
    tgi_pkg::in_item_t  it;
    bit                 known;
    tgi_pkg::out_item_t res;
  } row_t;

  initial begin
    row_t rows [$];
    tgi_pkg::in_item_t it;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    quiet_rx = 1;
    @(negedge clk_i);

    // fast grid load without idling, samples kept small
    load_axis(0, 32'sh8000_0000, 32'h0800_0000);
    load_axis(1, -32'sd1000, 4000);
    load_axis(2, 32'sd0, 200000);
    load_field(0, 1000);
    quiet_rx = 0;

    rows.push_back('{mk_q(32'h8000_0000, ax_tab[1][0], ax_tab[2][0]), 0, '0});
    rows.push_back('{mk_q(ax_tab[0][N-1], ax_tab[1][N-1], ax_tab[2][N-1]), 0, '0});
    rows.push_back('{mk_q(ax_tab[0][N-1] + 1, ax_tab[1][0], ax_tab[2][0]), 1,
                     '{0, tgi_pkg::STATUS_OUT_OF_BOX}});
    rows.push_back('{mk_q(ax_tab[0][0], ax_tab[1][0] - 1, ax_tab[2][0]), 1,
                     '{0, tgi_pkg::STATUS_OUT_OF_BOX}});
    rows.push_back('{mk_q(ax_tab[0][0], ax_tab[1][0], 32'h7fff_ffff), 1,
                     '{0, tgi_pkg::STATUS_OUT_OF_BOX}});
    rows.push_back('{mk_q(pick_in(0), pick_in(1), pick_in(2)), 0, '0});
    rows.push_back('{mk(tgi_pkg::kind_e'(3'd5), 0, 0), 0, '0});
    rows.push_back('{mk(tgi_pkg::kind_e'(3'd7), 4095, 32'hffff_ffff), 0, '0});
    rows.push_back('{mk(tgi_pkg::KIND_LOAD_X, 16, 0), 0, '0});
    rows.push_back('{mk(tgi_pkg::KIND_LOAD_Z, 4095, 32'h7fff_ffff), 0, '0});
    rows.push_back('{mk(tgi_pkg::KIND_LOAD_S, 4095, 32'h7fff_ffff), 0, '0});
    rows.push_back('{mk(tgi_pkg::KIND_LOAD_S, 0, 32'h8000_0000), 0, '0});
    rows.push_back('{mk_q(ax_tab[0][N-1], ax_tab[1][N-1], ax_tab[2][N-1]), 0, '0});
    rows.push_back('{mk_q(ax_tab[0][0], ax_tab[1][0], ax_tab[2][0]), 0, '0});
    // duplicate entry on y
    rows.push_back('{mk(tgi_pkg::KIND_LOAD_Y, 3, ax_tab[1][2]), 0, '0});
    rows.push_back('{mk_q(ax_tab[0][0], ax_tab[1][0], ax_tab[2][0]), 1,
                     '{0, tgi_pkg::STATUS_NOT_ASCENDING}});
    rows.push_back('{mk_q(ax_tab[0][0] - 1, ax_tab[1][0], ax_tab[2][0]), 1,
                     '{0, tgi_pkg::STATUS_OUT_OF_BOX}});
    rows.push_back('{mk(tgi_pkg::KIND_LOAD_Y, 3, ax_tab[1][3]), 0, '0});
    foreach (rows[r]) begin
      send(rows[r].it);
      if (rows[r].known && pending_q[$] !== rows[r].res) begin
        $error("table row %0d: predictor gives %0d/%0d", r,
               pending_q[$].interpolated, pending_q[$].status);
        err_cnt++;
      end
    end
    drain();

    // receiver holds off while queries pile up
    hold_cycles <= 800;
    for (int n = 0; n < 6; n++) send(mk_q(pick_in(0), pick_in(1), pick_in(2)));
    drain();

    // random phases: grid loads then mostly in-box queries, with noise
    for (int ph = 0; ph < 2; ph++) begin
      quiet_rx = 1;
      load_axis(0, $urandom_range(200000) - 100000, ph == 1 ? 32'h0700_0000 : 100000);
      load_axis(1, $urandom, 50000);
      load_axis(2, $urandom_range(1000), 3);
      load_field(ph != 0, 30000);
      quiet_rx = ph == 1;
      for (int n = 0; n < 40; n++) begin
        case ($urandom_range(19))
          0: it = mk_q($urandom, $urandom, ax_tab[2][N-1] + 1 + $urandom_range(1000));
          1: begin
            it = mk_q($urandom, $urandom, $urandom);
            it.kind = 3'($urandom_range(7, 5));
          end
          2: it = mk(tgi_pkg::KIND_LOAD_S, $urandom_range(DEPTH - 1), $urandom);
          3: begin
            // break an axis, query it, then restore it
            send(mk(tgi_pkg::KIND_LOAD_X, 7, ax_tab[0][$urandom_range(1) ? 6 : 9]));
            send(mk_q(ax_tab[0][0], ax_tab[1][0], ax_tab[2][0]));
            it = mk(tgi_pkg::KIND_LOAD_X, 7, ax_tab[0][6] + 1);
            if (ax_tab[0][8] - ax_tab[0][6] < 2) it.load_value = ax_tab[0][8];
          end
          default: it = mk_q(pick_in(0), pick_in(1), pick_in(2));
        endcase
        send(it);
        // keep x[7] strictly between neighbours after the restore
        if (it.kind == tgi_pkg::KIND_LOAD_X && ax_tab[0][7] >= ax_tab[0][8])
          send(mk(tgi_pkg::KIND_LOAD_X, 7,
                  ax_tab[0][6] + (ax_tab[0][8] - ax_tab[0][6]) / 2));
      end
      drain();
    end
    quiet_rx = 0;

    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
